### design/pim_pkg.sv
// ============================================================================
// pim_pkg: shared definitions for the priority inheritance mutex
// Widths, operation and status codes, state encodings and the control
// structures that pass between the controller and the datapath.
// ============================================================================
package pim_pkg;

    localparam int MAX_WAITERS = 16;
    localparam int CNT_W       = $clog2(MAX_WAITERS + 1);
    localparam int ID_W        = 8;
    localparam int PRIO_W      = 8;
    localparam int TICK_W      = 32;
    localparam int NEST_W      = 16;
    localparam int KIND_W      = 2;
    localparam int STS_W       = 3;

    localparam logic [NEST_W-1:0] NEST_MAX = {NEST_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_PEND    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DELETE  = 2'd2
    } kind_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_TIMEOUT   = 3'd1,
        STS_NOT_OWNER = 3'd2,
        STS_QUEUED    = 3'd3,
        STS_FULL      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIND  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic find;
        logic exec;
        logic drain;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic multi;
        logic drain_last;
    } dp_sts_t;

    // Commands from the datapath to the wait queue.
    typedef struct packed {
        logic insert;
        logic shift;
    } q_cmd_t;

endpackage

### design/pim_req_if.sv
// ============================================================================
// pim_req_if: request channel of the priority inheritance mutex
// One beat carries one operation from one task.
// ============================================================================
interface pim_req_if
    import pim_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_prio;
    logic [TICK_W-1:0] wait_ticks;

    modport source (output valid, output kind, output task_id, output task_prio,
                    output wait_ticks, input ready);
    modport sink   (input valid, input kind, input task_id, input task_prio,
                    input wait_ticks, output ready);
endinterface

### design/pim_rsp_if.sv
// ============================================================================
// pim_rsp_if: response channel of the priority inheritance mutex
// One beat carries one result; the last beat of an operation has last set.
// ============================================================================
interface pim_rsp_if
    import pim_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic              prio_set_valid;
    logic [ID_W-1:0]   prio_task;
    logic [PRIO_W-1:0] prio_value;
    logic              wake_valid;
    logic [ID_W-1:0]   wake_task;
    logic              owned;
    logic [ID_W-1:0]   owner_task;
    logic [TICK_W-1:0] sleep_ticks;
    logic              last;

    modport source (output valid, output status, output prio_set_valid,
                    output prio_task, output prio_value, output wake_valid,
                    output wake_task, output owned, output owner_task,
                    output sleep_ticks, output last, input ready);
    modport sink   (input valid, input status, input prio_set_valid,
                    input prio_task, input prio_value, input wake_valid,
                    input wake_task, input owned, input owner_task,
                    input sleep_ticks, input last, output ready);
endinterface

### design/pim_queue.sv
// ============================================================================
// pim_queue: priority-sorted wait queue
// A row of cells that shifts right from the insert point or left from the
// head, plus the search for the insert position.
// ============================================================================
module pim_queue
    import pim_pkg::*;
(
    input  logic              clk,
    input  q_cmd_t            cmd,
    input  logic [CNT_W-1:0]  count,
    input  logic [CNT_W-1:0]  ins_pos,
    input  logic [ID_W-1:0]   new_id,
    input  logic [PRIO_W-1:0] new_prio,
    output logic [CNT_W-1:0]  find_pos,
    output logic [ID_W-1:0]   head_id,
    output logic [PRIO_W-1:0] head_prio
);

    logic [ID_W-1:0]   id_reg   [MAX_WAITERS];
    logic [PRIO_W-1:0] prio_reg [MAX_WAITERS];

    // The new waiter goes in front of the first strictly less urgent one.
    always_comb
    begin
        find_pos = count;
        for (int i = MAX_WAITERS - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < count) && (new_prio < prio_reg[i]))
            begin
                find_pos = CNT_W'(i);
            end
        end
    end

    assign head_id   = id_reg[0];
    assign head_prio = prio_reg[0];

    for (genvar gi = 0; gi < MAX_WAITERS; gi++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
        logic [ID_W-1:0]   left_id;
        logic [PRIO_W-1:0] left_prio;
        logic [ID_W-1:0]   right_id;
        logic [PRIO_W-1:0] right_prio;

        if (gi > 0)
        begin : g_left
            assign left_id   = id_reg[gi-1];
            assign left_prio = prio_reg[gi-1];
        end
        else
        begin : g_left0
            assign left_id   = id_reg[gi];
            assign left_prio = prio_reg[gi];
        end

        if (gi < MAX_WAITERS - 1)
        begin : g_right
            assign right_id   = id_reg[gi+1];
            assign right_prio = prio_reg[gi+1];
        end
        else
        begin : g_right_end
            assign right_id   = id_reg[gi];
            assign right_prio = prio_reg[gi];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (IDX == ins_pos)
                begin
                    id_reg[gi]   <= new_id;
                    prio_reg[gi] <= new_prio;
                end
                else if (IDX > ins_pos)
                begin
                    id_reg[gi]   <= left_id;
                    prio_reg[gi] <= left_prio;
                end
            end
            else if (cmd.shift)
            begin
                id_reg[gi]   <= right_id;
                prio_reg[gi] <= right_prio;
            end
        end
    end

endmodule

### design/pim_dp.sv
// ============================================================================
// pim_dp: datapath of the priority inheritance mutex
// Holds the mutex state and the wait queue, works out each result and keeps
// it in the output register until it is taken.
// ============================================================================
module pim_dp
    import pim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic [KIND_W-1:0] kind,
    input  logic [ID_W-1:0]   task_id,
    input  logic [PRIO_W-1:0] task_prio,
    input  logic [TICK_W-1:0] wait_ticks,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [STS_W-1:0]  status,
    output logic              prio_set_valid,
    output logic [ID_W-1:0]   prio_task,
    output logic [PRIO_W-1:0] prio_value,
    output logic              wake_valid,
    output logic [ID_W-1:0]   wake_task,
    output logic              owned,
    output logic [ID_W-1:0]   owner_task,
    output logic [TICK_W-1:0] sleep_ticks,
    output logic              last
);

    // Latched operation.
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [CNT_W-1:0]  pos_reg;

    // Mutex state.
    logic [ID_W-1:0]   owner_reg, owner_next;
    logic [NEST_W-1:0] nest_reg, nest_next;
    logic [PRIO_W-1:0] saved_reg, saved_next;
    logic [PRIO_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  drain_reg, drain_next;

    // Result being built and the output register.
    status_t           res_status;
    logic              res_pv;
    logic [ID_W-1:0]   res_pt;
    logic [PRIO_W-1:0] res_pval;
    logic              res_wv;
    logic [ID_W-1:0]   res_wt;
    logic [TICK_W-1:0] res_sleep;
    logic              res_last;
    logic              ov_reg;
    logic              load;

    q_cmd_t            q_cmd;
    logic [CNT_W-1:0]  find_pos;
    logic [ID_W-1:0]   head_id;
    logic [PRIO_W-1:0] head_prio;

    pim_queue u_queue (
        .clk       (clk),
        .cmd       (q_cmd),
        .count     (count_reg),
        .ins_pos   (pos_reg),
        .new_id    (id_reg),
        .new_prio  (prio_reg),
        .find_pos  (find_pos),
        .head_id   (head_id),
        .head_prio (head_prio)
    );

    assign load = cmd.exec | cmd.drain;

    always_comb
    begin
        owner_next = owner_reg;
        nest_next  = nest_reg;
        saved_next = saved_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        drain_next = drain_reg;
        res_status = STS_OK;
        res_pv     = 1'b0;
        res_pt     = '0;
        res_pval   = '0;
        res_wv     = 1'b0;
        res_wt     = '0;
        res_sleep  = '0;
        res_last   = 1'b1;
        q_cmd      = '0;

        if (cmd.exec)
        begin
            case (kind_t'(kind_reg))
                KIND_PEND:
                begin
                    if (nest_reg == '0)
                    begin
                        owner_next = id_reg;
                        saved_next = prio_reg;
                        cur_next   = prio_reg;
                        nest_next  = NEST_W'(1);
                    end
                    else if (owner_reg == id_reg)
                    begin
                        if (nest_reg != NEST_MAX)
                        begin
                            nest_next = nest_reg + NEST_W'(1);
                        end
                    end
                    else if (ticks_reg == '0)
                    begin
                        res_status = STS_TIMEOUT;
                    end
                    else
                    begin
                        if (cur_reg > prio_reg)
                        begin
                            cur_next = prio_reg;
                            res_pv   = 1'b1;
                            res_pt   = owner_reg;
                            res_pval = prio_reg;
                        end
                        if (count_reg >= CNT_W'(MAX_WAITERS))
                        begin
                            res_status = STS_FULL;
                        end
                        else
                        begin
                            q_cmd.insert = 1'b1;
                            count_next   = count_reg + CNT_W'(1);
                            res_status   = STS_QUEUED;
                            res_sleep    = ticks_reg;
                        end
                    end
                end
                KIND_RELEASE:
                begin
                    if ((nest_reg == '0) || (owner_reg != id_reg))
                    begin
                        res_status = STS_NOT_OWNER;
                    end
                    else if (nest_reg != NEST_W'(1))
                    begin
                        nest_next = nest_reg - NEST_W'(1);
                    end
                    else
                    begin
                        if (cur_reg != saved_reg)
                        begin
                            res_pv   = 1'b1;
                            res_pt   = owner_reg;
                            res_pval = saved_reg;
                        end
                        if (count_reg != '0)
                        begin
                            res_wv      = 1'b1;
                            res_wt      = head_id;
                            owner_next  = head_id;
                            saved_next  = head_prio;
                            cur_next    = head_prio;
                            nest_next   = NEST_W'(1);
                            q_cmd.shift = 1'b1;
                            count_next  = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            owner_next = '0;
                            cur_next   = '0;
                            nest_next  = '0;
                        end
                    end
                end
                KIND_DELETE:
                begin
                    if ((nest_reg != '0) && (cur_reg != saved_reg))
                    begin
                        res_pv   = 1'b1;
                        res_pt   = owner_reg;
                        res_pval = saved_reg;
                        cur_next = saved_reg;
                    end
                    count_next = '0;
                    if (count_reg != '0)
                    begin
                        res_wv      = 1'b1;
                        res_wt      = head_id;
                        q_cmd.shift = 1'b1;
                        drain_next  = count_reg - CNT_W'(1);
                        res_last    = (count_reg == CNT_W'(1));
                    end
                end
                default:
                begin
                    res_status = STS_OK;
                end
            endcase
        end
        else if (cmd.drain)
        begin
            res_wv      = 1'b1;
            res_wt      = head_id;
            q_cmd.shift = 1'b1;
            drain_next  = drain_reg - CNT_W'(1);
            res_last    = (drain_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            nest_reg  <= '0;
            saved_reg <= '0;
            cur_reg   <= '0;
            count_reg <= '0;
            drain_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            owner_reg <= owner_next;
            nest_reg  <= nest_next;
            saved_reg <= saved_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            drain_reg <= drain_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg  <= kind;
            id_reg    <= task_id;
            prio_reg  <= task_prio;
            ticks_reg <= wait_ticks;
        end
        if (cmd.find)
        begin
            pos_reg <= find_pos;
        end
        if (load)
        begin
            status         <= res_status;
            prio_set_valid <= res_pv;
            prio_task      <= res_pt;
            prio_value     <= res_pval;
            wake_valid     <= res_wv;
            wake_task      <= res_wt;
            owned          <= (nest_next != '0);
            owner_task     <= (nest_next != '0) ? owner_next : '0;
            sleep_ticks    <= res_sleep;
            last           <= res_last;
        end
    end

    assign out_valid      = ov_reg;
    assign sts.out_free   = ~ov_reg | out_ready;
    assign sts.multi      = (kind_t'(kind_reg) == KIND_DELETE) && (count_reg > CNT_W'(1));
    assign sts.drain_last = (drain_reg == CNT_W'(1));

endmodule

### design/pim_ctrl.sv
// ============================================================================
// pim_ctrl: controller of the priority inheritance mutex
// Sequences accept, position search, execution and the delete drain.
// ============================================================================
module pim_ctrl
    import pim_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cmd.latch = in_valid & in_ready;
    assign cmd.find  = (state_reg == ST_FIND);
    assign cmd.exec  = (state_reg == ST_EXEC) & sts.out_free;
    assign cmd.drain = (state_reg == ST_DRAIN) & sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.latch)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.multi ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (sts.out_free && sts.drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/priority_inheritance_mutex.sv
// ============================================================================
// priority_inheritance_mutex: recursive mutex with priority inheritance
// Top level: controller, datapath and sorted wait queue behind two
// valid/ready channels.
// ============================================================================
// Each request beat is a pend, release or delete from one task. A pend or a
// release runs through these steps in order: the request is accepted and
// latched; the wait queue compares the caller's priority against every
// waiter to find the insert point; the mutex state and the queue are updated
// and the result beat is loaded into the output register. A delete with n
// waiters, n at least one, gives n result beats, one per cycle while the
// consumer keeps taking them: the first from the update step, the rest from
// the drain step. A delete with no waiters gives a single beat. A result
// beat that the consumer has not taken yet stalls the update or drain step
// until the output register frees up. The block runs this latch, search and
// update sequence for one request at a time. A new request is taken in the
// cycle after the final result beat of the previous one has been loaded,
// even while that beat still waits in the output register. The queue holds
// up to MAX_WAITERS tasks kept in priority order, with tasks of equal
// priority in arrival order. The last result beat of every request has last
// set.
// ============================================================================
module priority_inheritance_mutex
    import pim_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    pim_req_if.sink  req,
    pim_rsp_if.source rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_ready;

    // The controller only decides when things happen; every value lives in
    // the datapath.
    pim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pim_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (req.kind),
        .task_id        (req.task_id),
        .task_prio      (req.task_prio),
        .wait_ticks     (req.wait_ticks),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .status         (rsp.status),
        .prio_set_valid (rsp.prio_set_valid),
        .prio_task      (rsp.prio_task),
        .prio_value     (rsp.prio_value),
        .wake_valid     (rsp.wake_valid),
        .wake_task      (rsp.wake_task),
        .owned          (rsp.owned),
        .owner_task     (rsp.owner_task),
        .sleep_ticks    (rsp.sleep_ticks),
        .last           (rsp.last)
    );

    assign req.ready = in_ready;

    // Only one request is in flight: after a request beat is taken, the
    // block does not take another in the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in progress");

    // Only the delete drain produces more than one result beat, and each of
    // its beats wakes a waiter.
    a_nonlast_wakes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> rsp.wake_valid)
        else $error("non-final result beat without a wake");

    // A queued pender always waits on a held mutex.
    a_queued_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STS_QUEUED)) |-> rsp.owned)
        else $error("task queued on a free mutex");

    // A free mutex reports no owner.
    a_free_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.owned) |-> (rsp.owner_task == '0))
        else $error("free mutex reports an owner");

endmodule
